// ===== design/tun_pkg.sv =====
package tun_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int NORM_TOP_BITS        = 30;

endpackage

// ===== design/tun_if.sv =====
interface tun_vtx_if import tun_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;
  logic signed [CW-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface

interface tun_nrm_if import tun_pkg::*; #(
  parameter int FB = NORMAL_FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [FB+1:0] normal_x;
  logic signed [FB+1:0] normal_y;
  logic signed [FB+1:0] normal_z;
  logic                 degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== design/triangle_unit_normal.sv =====
// Unit face normal of a triangle. Edges b-a and c-a are crossed exactly, the
// cross product is scaled so its largest magnitude lands in [2^29, 2^30), its
// length is taken by a bit-per-stage square root, and each component is
// divided by that length (rounded) by a bit-per-stage divider, giving signed
// values with NORMAL_FRAC_BITS fraction bits. A zero cross product gives a
// zero normal and raises degenerate. Fully pipelined: one triangle per cycle
// when not stalled, through the 31 root stages and the divider stages. An
// output register with a skid word keeps input flowing while a result waits;
// the pipeline stalls only once the skid word is full.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  tun_vtx_if.sink         vtx,
  tun_nrm_if.source       nrm
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = NORMAL_FRAC_BITS;
  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int MW  = 2 * CW + 1;
  localparam int KW  = $clog2(MW + 1);
  localparam int UW  = NORM_TOP_BITS;
  localparam int SW  = 2 * UW + 2;
  localparam int LW  = SW / 2;
  localparam int RW  = LW + 3;
  localparam int QW  = FB + 1;
  localparam int OW  = FB + 2;
  localparam int DW  = UW + FB + 1;

  logic en;
  logic skv;
  assign en = !skv;
  assign vtx.ready = en;

  // stage 1: edges
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic v1;
  always_ff @(posedge clk) begin
    if (en) begin
      e1x <= EW'(vtx.b_x) - EW'(vtx.a_x);
      e1y <= EW'(vtx.b_y) - EW'(vtx.a_y);
      e1z <= EW'(vtx.b_z) - EW'(vtx.a_z);
      e2x <= EW'(vtx.c_x) - EW'(vtx.a_x);
      e2y <= EW'(vtx.c_y) - EW'(vtx.a_y);
      e2z <= EW'(vtx.c_z) - EW'(vtx.a_z);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic v2;
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= PW'(e1y) * PW'(e2z);
      p1 <= PW'(e1z) * PW'(e2y);
      p2 <= PW'(e1z) * PW'(e2x);
      p3 <= PW'(e1x) * PW'(e2z);
      p4 <= PW'(e1x) * PW'(e2y);
      p5 <= PW'(e1y) * PW'(e2x);
    end
  end

  // stage 3: cross product
  logic signed [PW-1:0] cr [3];
  logic v3;
  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= p0 - p1;
      cr[1] <= p2 - p3;
      cr[2] <= p4 - p5;
    end
  end

  // stage 4: sign and magnitude
  logic [MW-1:0] mag4 [3];
  logic [2:0]    neg4;
  logic          deg4;
  logic          v4;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag4[i] <= cr[i][PW-1] ? MW'(-cr[i]) : MW'(cr[i]);
        neg4[i] <= cr[i][PW-1];
      end
      deg4 <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
    end
  end

  // stage 5: bit length of the largest magnitude
  logic [MW-1:0] orv;
  logic [KW-1:0] kc;
  always_comb begin
    orv = mag4[0] | mag4[1] | mag4[2];
    kc  = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) kc = KW'(i + 1);
    end
  end

  logic [MW-1:0] mag5 [3];
  logic [KW-1:0] k5;
  logic [2:0]    neg5;
  logic          deg5;
  logic          v5;
  always_ff @(posedge clk) begin
    if (en) begin
      mag5 <= mag4;
      k5   <= kc;
      neg5 <= neg4;
      deg5 <= deg4;
    end
  end

  // stage 6: common normalizing shift
  logic [UW-1:0] u6 [3];
  logic [2:0]    neg6;
  logic          deg6;
  logic          v6;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u6[i] <= UW'({mag5[i], {UW{1'b0}}} >> k5);
      end
      neg6 <= neg5;
      deg6 <= deg5;
    end
  end

  // stage 7: squares
  logic [2*UW-1:0] sq7 [3];
  logic [UW-1:0]   u7 [3];
  logic [2:0]      neg7;
  logic            deg7;
  logic            v7;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq7[i] <= (2*UW)'(u6[i]) * (2*UW)'(u6[i]);
      end
      u7   <= u6;
      neg7 <= neg6;
      deg7 <= deg6;
    end
  end

  // stage 8: sum of squares
  logic [SW-1:0] sum8;
  logic [UW-1:0] u8 [3];
  logic [2:0]    neg8;
  logic          deg8;
  logic          v8;
  always_ff @(posedge clk) begin
    if (en) begin
      sum8 <= SW'(sq7[0]) + SW'(sq7[1]) + SW'(sq7[2]);
      u8   <= u7;
      neg8 <= neg7;
      deg8 <= deg7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else if (en) begin
      v1 <= vtx.valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
    end
  end

  // square root, one root bit per stage
  logic [SW-1:0] sr   [LW];
  logic [LW-1:0] rt   [LW];
  logic [RW-1:0] rm   [LW];
  logic [UW-1:0] su   [LW][3];
  logic [2:0]    sneg [LW];
  logic          sdeg [LW];
  logic          sv   [LW];

  for (genvar j = 0; j < LW; j++) begin : g_sqrt
    logic [SW-1:0] s_in;
    logic [LW-1:0] r_in;
    logic [RW-1:0] m_in;
    logic [UW-1:0] u_in [3];
    logic [2:0]    n_in;
    logic          d_in;
    logic          v_in;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign s_in = sum8;
      assign r_in = '0;
      assign m_in = '0;
      assign u_in = u8;
      assign n_in = neg8;
      assign d_in = deg8;
      assign v_in = v8;
    end else begin : g_next
      assign s_in = sr[j-1];
      assign r_in = rt[j-1];
      assign m_in = rm[j-1];
      assign u_in = su[j-1];
      assign n_in = sneg[j-1];
      assign d_in = sdeg[j-1];
      assign v_in = sv[j-1];
    end

    assign cur   = {m_in[RW-3:0], s_in[SW-1:SW-2]};
    assign trial = RW'({r_in, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sr[j]   <= s_in << 2;
        rm[j]   <= ge ? cur - trial : cur;
        rt[j]   <= {r_in[LW-2:0], ge};
        su[j]   <= u_in;
        sneg[j] <= n_in;
        sdeg[j] <= d_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j] <= 1'b0;
      end else if (en) begin
        sv[j] <= v_in;
      end
    end
  end

  // divider setup: rounded dividend
  logic [DW-1:0] dd [3];
  logic [LW-1:0] len;
  logic [2:0]    pneg;
  logic          pdeg;
  logic          pv;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd[i] <= DW'({su[LW-1][i], {FB{1'b0}}}) + DW'(rt[LW-1] >> 1);
      end
      len  <= rt[LW-1];
      pneg <= sneg[LW-1];
      pdeg <= sdeg[LW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= sv[LW-1];
    end
  end

  // restoring division, one quotient bit per stage
  logic [LW-1:0] dr   [QW][3];
  logic [QW-1:0] dl   [QW][3];
  logic [QW-1:0] dq   [QW][3];
  logic [LW-1:0] dlen [QW];
  logic [2:0]    dneg [QW];
  logic          ddeg [QW];
  logic          dv   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [LW-1:0] r_in [3];
    logic [QW-1:0] l_in [3];
    logic [QW-1:0] q_in [3];
    logic [LW-1:0] len_in;
    logic [2:0]    n_in;
    logic          d_in;
    logic          v_in;

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign r_in[i] = LW'(dd[i][DW-1:QW]);
        assign l_in[i] = dd[i][QW-1:0];
        assign q_in[i] = '0;
      end
      assign len_in = len;
      assign n_in   = pneg;
      assign d_in   = pdeg;
      assign v_in   = pv;
    end else begin : g_next
      assign r_in   = dr[j-1];
      assign l_in   = dl[j-1];
      assign q_in   = dq[j-1];
      assign len_in = dlen[j-1];
      assign n_in   = dneg[j-1];
      assign d_in   = ddeg[j-1];
      assign v_in   = dv[j-1];
    end

    always_ff @(posedge clk) begin
      logic [LW:0] cur;
      logic        ge;
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          cur = {r_in[i], l_in[i][QW-1-j]};
          ge  = cur >= {1'b0, len_in};
          dr[j][i] <= ge ? LW'(cur - {1'b0, len_in}) : LW'(cur);
          dq[j][i] <= {q_in[i][QW-2:0], ge};
        end
        dl[j]   <= l_in;
        dlen[j] <= len_in;
        dneg[j] <= n_in;
        ddeg[j] <= d_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= v_in;
      end
    end
  end

  // signed result
  logic signed [OW-1:0] fn [3];
  logic                 fdeg;
  logic                 fv;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ddeg[QW-1]) begin
        fn[i] = '0;
      end else if (dneg[QW-1][i]) begin
        fn[i] = -OW'(dq[QW-1][i]);
      end else begin
        fn[i] = OW'(dq[QW-1][i]);
      end
    end
    fdeg = ddeg[QW-1];
    fv   = dv[QW-1];
  end

  // output word and skid word
  logic signed [OW-1:0] on [3];
  logic signed [OW-1:0] sk [3];
  logic                 odeg, sdg;
  logic                 ov;
  logic                 take;
  assign take = nrm.ready || !ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      skv <= 1'b0;
    end else if (take) begin
      if (skv) begin
        ov  <= 1'b1;
        skv <= 1'b0;
      end else begin
        ov <= fv;
      end
    end else if (fv && en) begin
      skv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skv) begin
        on   <= sk;
        odeg <= sdg;
      end else begin
        on   <= fn;
        odeg <= fdeg;
      end
    end else if (en) begin
      sk  <= fn;
      sdg <= fdeg;
    end
  end

  assign nrm.valid      = ov;
  assign nrm.normal_x   = on[0];
  assign nrm.normal_y   = on[1];
  assign nrm.normal_z   = on[2];
  assign nrm.degenerate = odeg;

  localparam logic signed [OW-1:0] ONE = OW'(1) << FB;

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    ov && odeg |-> on[0] == '0 && on[1] == '0 && on[2] == '0)
    else $error("degenerate word with nonzero normal");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skv |-> ov)
    else $error("skid word held without output word");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    ov |-> on[0] <= ONE && on[0] >= -ONE && on[1] <= ONE && on[1] >= -ONE
        && on[2] <= ONE && on[2] >= -ONE)
    else $error("normal component beyond one");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !ov && !skv)
    else $error("word present after reset");

endmodule
